// File: rtl/cse_pkg.sv
// shared types and constants of the checked int64 stack evaluator
// no dependencies; imported by cse_alu and the top level
package cse_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int NUM_VARS    = 8;
  localparam int VAR_IDX_W   = 3;

  // item kinds
  localparam logic [3:0] K_END  = 4'd0;
  localparam logic [3:0] K_PUSHC = 4'd1;
  localparam logic [3:0] K_PUSHV = 4'd2;
  localparam logic [3:0] K_ADD  = 4'd3;
  localparam logic [3:0] K_SUB  = 4'd4;
  localparam logic [3:0] K_MUL  = 4'd5;
  localparam logic [3:0] K_DIV  = 4'd6;
  localparam logic [3:0] K_REM  = 4'd7;
  localparam logic [3:0] K_POW  = 4'd8;
  localparam logic [3:0] K_MIN  = 4'd9;
  localparam logic [3:0] K_MAX  = 4'd10;
  localparam logic [3:0] K_NEG  = 4'd11;
  localparam logic [3:0] K_ABS  = 4'd12;

  // error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_PROGRAM  = 3'd1;
  localparam logic [2:0] ERR_OVERFLOW = 3'd2;
  localparam logic [2:0] ERR_NEGPOW   = 3'd3;
  localparam logic [2:0] ERR_DIVZERO  = 3'd4;

  // shared unit operations
  localparam logic [1:0] ALU_MUL = 2'd0;
  localparam logic [1:0] ALU_DIV = 2'd1;
  localparam logic [1:0] ALU_REM = 2'd2;

  localparam logic [63:0] MIN_S64 = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic               start;
    logic [1:0]         op;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } alu_req_t;

  typedef struct packed {
    logic               done;
    logic               ovf;
    logic signed [63:0] value;
  } alu_rsp_t;

endpackage

// File: rtl/checked_int64_stack_evaluator_core.sv
// checked int64 postfix stack evaluator, top level
// depends on cse_pkg and cse_alu
//
// usage: each input item is one postfix instruction (in_kind with its
// constant or variable index). items are taken when in_valid and in_ready
// are high; in_ready is high only while the sequencer is idle. an END item
// produces one result item (value and error code) on the out_ channel;
// other items produce nothing. variables are written through cfg_; the user
// must write them only while idle; the block itself has no check for this.
// push, error-skipped and unknown items finish in the idle state; neg/abs
// and binary items read the stack first; mul, div, rem and pow (up to 63
// multiplies) then use the shared multiply/divide unit, one bit per cycle.
// a finished result sits in the output register while further non-END
// items are processed; an END waits only if that register is still full.
// reset (synchronous, active low) empties the stack, clears the latched
// error, zeroes the variables and drops out_valid. the stack memory itself
// is not cleared: only entries below the depth are ever used.
module checked_int64_stack_evaluator_core import cse_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [3:0]           in_kind,
  input  logic signed [63:0]   in_constant_value,
  input  logic [VAR_IDX_W-1:0] in_variable_index,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [63:0]   out_result_value,
  output logic [2:0]           out_error_code,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_addr,
  input  logic [63:0]          cfg_wdata
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RDB  = 3'd1;
  localparam logic [2:0] ST_RDA  = 3'd2;
  localparam logic [2:0] ST_EXE  = 3'd3;
  localparam logic [2:0] ST_WAIT = 3'd4;
  localparam logic [2:0] ST_POW  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0]         state_r, state_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [2:0]         err_r, err_nxt;
  logic [3:0]         kind_r;
  logic [5:0]         pcnt_r, pcnt_nxt;
  logic signed [63:0] a_r, b_r;
  logic signed [63:0] vars_r [NUM_VARS];
  logic [63:0]        stack_mem [STACK_DEPTH];
  logic [63:0]        rd_data_r;
  logic               rd_en, wr_en;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;
  logic [63:0]        wr_data;
  logic               out_valid_r;
  logic signed [63:0] out_value_r;
  logic [2:0]         out_code_r;
  logic               in_acc, out_load;
  logic [DEPTH_W-1:0] dm1, dm2;
  logic [64:0]        sum65, dif65;
  logic               start;
  alu_req_t           req;
  alu_rsp_t           rsp;

  cse_alu u_alu (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  assign in_ready         = (state_r == ST_IDLE);
  assign in_acc           = in_valid && in_ready;
  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_error_code   = out_code_r;
  assign dm1              = depth_r - DEPTH_W'(1);
  assign dm2              = depth_r - DEPTH_W'(2);
  assign sum65            = {a_r[63], a_r} + {b_r[63], b_r};
  assign dif65            = {a_r[63], a_r} - {b_r[63], b_r};
  assign out_load         = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  // shared unit request
  always_comb begin
    req.start = start;
    req.op    = (kind_r == K_DIV) ? ALU_DIV : (kind_r == K_REM) ? ALU_REM : ALU_MUL;
    req.a     = a_r;
    req.b     = b_r;
    if (kind_r == K_POW) begin
      req.a = (state_r == ST_EXE) ? 64'sd1 : rsp.value;
      req.b = a_r;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    depth_nxt = depth_r;
    err_nxt   = err_r;
    pcnt_nxt  = pcnt_r;
    rd_en     = 1'b0;
    rd_addr   = dm1[ADDR_W-1:0];
    wr_en     = 1'b0;
    wr_addr   = dm2[ADDR_W-1:0];
    wr_data   = 64'd0;
    start     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_kind == K_END) begin
            rd_en     = 1'b1;
            rd_addr   = '0;
            state_nxt = ST_FIN;
          end else if (err_r != ERR_NONE || in_kind > K_ABS) begin
            state_nxt = ST_IDLE;
          end else if (in_kind == K_PUSHC || in_kind == K_PUSHV) begin
            if (depth_r >= DEPTH_W'(STACK_DEPTH)) begin
              err_nxt = ERR_PROGRAM;
            end else begin
              wr_en     = 1'b1;
              wr_addr   = depth_r[ADDR_W-1:0];
              wr_data   = in_constant_value;
              if (in_kind == K_PUSHV) begin
                wr_data = ({1'b0, in_variable_index} < 4'(NUM_VARS)) ?
                          vars_r[in_variable_index] : 64'd0;
              end
              depth_nxt = depth_r + DEPTH_W'(1);
            end
          end else if (in_kind == K_NEG || in_kind == K_ABS) begin
            if (depth_r == '0) begin
              err_nxt = ERR_PROGRAM;
            end else begin
              rd_en     = 1'b1;
              state_nxt = ST_RDB;
            end
          end else begin
            if (depth_r < DEPTH_W'(2)) begin
              err_nxt = ERR_PROGRAM;
            end else begin
              rd_en     = 1'b1;
              state_nxt = ST_RDB;
            end
          end
        end
      end
      ST_RDB: begin
        if (kind_r == K_NEG || kind_r == K_ABS) begin
          if (rd_data_r == MIN_S64) begin
            err_nxt = ERR_OVERFLOW;
          end else if (kind_r == K_NEG || rd_data_r[63]) begin
            wr_en   = 1'b1;
            wr_addr = dm1[ADDR_W-1:0];
            wr_data = -rd_data_r;
          end
          state_nxt = ST_IDLE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = dm2[ADDR_W-1:0];
          state_nxt = ST_RDA;
        end
      end
      ST_RDA: state_nxt = ST_EXE;
      ST_EXE: begin
        state_nxt = ST_IDLE;
        wr_addr   = dm2[ADDR_W-1:0];
        case (kind_r)
          K_ADD, K_SUB: begin
            if (kind_r == K_ADD ? (sum65[64] != sum65[63]) : (dif65[64] != dif65[63])) begin
              err_nxt = ERR_OVERFLOW;
            end else begin
              wr_en     = 1'b1;
              wr_data   = (kind_r == K_ADD) ? sum65[63:0] : dif65[63:0];
              depth_nxt = dm1;
            end
          end
          K_MIN, K_MAX: begin
            wr_en     = 1'b1;
            wr_data   = ((a_r < b_r) == (kind_r == K_MIN)) ? a_r : b_r;
            depth_nxt = dm1;
          end
          K_MUL: begin
            start     = 1'b1;
            state_nxt = ST_WAIT;
          end
          K_DIV, K_REM: begin
            if (b_r == 64'sd0) begin
              err_nxt = ERR_DIVZERO;
            end else if (kind_r == K_DIV && a_r == MIN_S64 && b_r == -64'sd1) begin
              err_nxt = ERR_OVERFLOW;
            end else begin
              start     = 1'b1;
              state_nxt = ST_WAIT;
            end
          end
          K_POW: begin
            if (b_r[63]) begin
              err_nxt = ERR_NEGPOW;
            end else if (b_r == 64'sd0 || a_r == 64'sd0 || a_r == 64'sd1 ||
                         a_r == -64'sd1) begin
              wr_en     = 1'b1;
              depth_nxt = dm1;
              if (b_r == 64'sd0) begin
                wr_data = 64'd1;
              end else if (a_r == -64'sd1) begin
                wr_data = b_r[0] ? -64'sd1 : 64'sd1;
              end else begin
                wr_data = a_r;
              end
            end else if (b_r > 64'sd63) begin
              err_nxt = ERR_OVERFLOW;
            end else begin
              pcnt_nxt  = b_r[5:0];
              start     = 1'b1;
              state_nxt = ST_POW;
            end
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_WAIT: begin
        if (rsp.done) begin
          state_nxt = ST_IDLE;
          if (rsp.ovf) begin
            err_nxt = ERR_OVERFLOW;
          end else begin
            wr_en     = 1'b1;
            wr_data   = rsp.value;
            depth_nxt = dm1;
          end
        end
      end
      ST_POW: begin
        if (rsp.done) begin
          if (rsp.ovf) begin
            err_nxt   = ERR_OVERFLOW;
            state_nxt = ST_IDLE;
          end else if (pcnt_r == 6'd1) begin
            wr_en     = 1'b1;
            wr_data   = rsp.value;
            depth_nxt = dm1;
            state_nxt = ST_IDLE;
          end else begin
            pcnt_nxt = pcnt_r - 6'd1;
            start    = 1'b1;
          end
        end
      end
      ST_FIN: begin
        if (out_load) begin
          depth_nxt = '0;
          err_nxt   = ERR_NONE;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // stack memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= stack_mem[rd_addr];
    end
  end

  // operand capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r <= in_kind;
    end
    if (state_r == ST_RDB) begin
      b_r <= rd_data_r;
    end
    if (state_r == ST_RDA) begin
      a_r <= rd_data_r;
    end
  end

  // control state, variables and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      depth_r     <= '0;
      err_r       <= ERR_NONE;
      pcnt_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_VARS; i++) begin
        vars_r[i] <= 64'sd0;
      end
    end else begin
      state_r <= state_nxt;
      depth_r <= depth_nxt;
      err_r   <= err_nxt;
      pcnt_r  <= pcnt_nxt;
      if (cfg_we && {1'b0, cfg_addr} < 4'(NUM_VARS)) begin
        vars_r[cfg_addr] <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (out_load) begin
      if (err_r != ERR_NONE) begin
        out_code_r  <= err_r;
        out_value_r <= 64'sd0;
      end else if (depth_r != DEPTH_W'(1)) begin
        out_code_r  <= ERR_PROGRAM;
        out_value_r <= 64'sd0;
      end else begin
        out_code_r  <= ERR_NONE;
        out_value_r <= rd_data_r;
      end
    end
  end

  // checks
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_W'(STACK_DEPTH)) else $error("stack depth out of range");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (state_r == ST_EXE || state_r == ST_POW)) else $error("unit start out of place");
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_kind == K_END |=> state_r == ST_FIN) else $error("end item not finished");
  a_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN)) else $error("result without end item");

endmodule

// File: rtl/cse_alu.sv
// iterative multiply / divide unit, one bit per cycle on 64-bit magnitudes
// depends on cse_pkg
module cse_alu import cse_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic        busy_r, done_r, big_r, neg_r, sa_r;
  logic [5:0]  cnt_r;
  logic [1:0]  op_r;
  logic [63:0] x_r, y_r, acc_r;
  logic [65:0] msum;
  logic [64:0] dsh, ddiff;
  logic        dge;

  // one shift-add or shift-subtract step
  always_comb begin
    msum  = {1'b0, acc_r, 1'b0} + {2'b00, (y_r[63] ? x_r : 64'd0)};
    dsh   = {acc_r, y_r[63]};
    ddiff = dsh - {1'b0, x_r};
    dge   = !ddiff[64];
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == 6'd0);
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 6'd0) begin
        busy_r <= 1'b0;
      end
    end
    if (req.start) begin
      op_r  <= req.op;
      cnt_r <= 6'd63;
      acc_r <= 64'd0;
      big_r <= 1'b0;
      neg_r <= req.a[63] ^ req.b[63];
      sa_r  <= req.a[63];
      if (req.op == ALU_MUL) begin
        x_r <= req.a[63] ? -req.a : req.a;
        y_r <= req.b[63] ? -req.b : req.b;
      end else begin
        x_r <= req.b[63] ? -req.b : req.b;
        y_r <= req.a[63] ? -req.a : req.a;
      end
    end else if (busy_r) begin
      cnt_r <= cnt_r - 6'd1;
      if (op_r == ALU_MUL) begin
        acc_r <= msum[63:0];
        big_r <= big_r | (msum[65:64] != 2'b00);
        y_r   <= {y_r[62:0], 1'b0};
      end else begin
        acc_r <= dge ? ddiff[63:0] : dsh[63:0];
        y_r   <= {y_r[62:0], dge};
      end
    end
  end

  // result shaping and overflow check
  always_comb begin
    rsp.done  = done_r;
    rsp.ovf   = 1'b0;
    rsp.value = acc_r;
    case (op_r)
      ALU_MUL: begin
        rsp.ovf   = big_r | (neg_r ? (acc_r > MIN_S64) : acc_r[63]);
        rsp.value = neg_r ? -acc_r : acc_r;
      end
      ALU_DIV: rsp.value = neg_r ? -y_r : y_r;
      ALU_REM: rsp.value = sa_r ? -acc_r : acc_r;
      default: rsp.value = acc_r;
    endcase
  end

endmodule
